// ===== src/isb_pkg.sv =====
// Shared constants, codes and control structs for the indexed block search.
`timescale 1ns / 1ps

package isb_pkg;

    // Table sizes
    localparam int MAX_RECORDS = 128;
    localparam int MAX_BLOCKS  = 16;
    localparam int REC_AW      = $clog2(MAX_RECORDS);
    localparam int BLK_AW      = $clog2(MAX_BLOCKS);

    // Field widths
    localparam int KEY_W   = 16;
    localparam int CNT_W   = 8;
    localparam int BCNT_W  = 5;
    localparam int PROBE_W = 3;

    // Divider runs one quotient bit per cycle over the count width
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Input function codes
    typedef enum logic [1:0] {
        FUNC_WR_REC = 2'd0,
        FUNC_WR_IDX = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic CFG_RECORD_COUNT = 1'b0;
    localparam logic CFG_BLOCK_COUNT  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_rec;      // write record key
        logic wr_idx;      // write index entry
        logic init;        // latch key and counts, start a search
        logic div_step;    // one quotient bit
        logic bs_step;     // one index probe
        logic scan_setup;  // load scan bounds from the chosen block
        logic scan_run;    // issue reads and compare
    } isb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bs_done;     // search interval empty
        logic lo_valid;    // chosen block lies inside the index
        logic scan_more;   // another record to read
        logic pend_vld;    // a read beat waits to be compared
        logic match;       // pending record key equals search key
    } isb_stat_t;

endpackage

// ===== src/isb_ctrl.sv =====
// Controller state machine for the indexed block search.
`timescale 1ns / 1ps

module isb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  isb_pkg::isb_stat_t stat,
    output isb_pkg::isb_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_BSRCH = 6'b000100,
        ST_SETUP = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [isb_pkg::DIV_CW-1:0]  div_cnt_reg, div_cnt_next;
    logic                        accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = (state_reg == ST_DONE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (isb_pkg::func_t'(func))
                        isb_pkg::FUNC_WR_REC: cmd.wr_rec = 1'b1;
                        isb_pkg::FUNC_WR_IDX: cmd.wr_idx = 1'b1;
                        isb_pkg::FUNC_SEARCH:
                        begin
                            cmd.init     = 1'b1;
                            div_cnt_next = '0;
                            state_next   = ST_DIV;
                        end
                        isb_pkg::FUNC_NOP: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == isb_pkg::DIV_CW'(isb_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_BSRCH;
                end
            end
            ST_BSRCH:
            begin
                if (!stat.bs_done)
                begin
                    cmd.bs_step = 1'b1;
                end
                else if (stat.lo_valid)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SETUP:
            begin
                cmd.scan_setup = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.match || (!stat.scan_more && !stat.pend_vld))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// ===== src/isb_dpath.sv =====
// Datapath for the indexed block search: tables, divider, index search, scan.
`timescale 1ns / 1ps

module isb_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  isb_pkg::isb_cmd_t           cmd,
    output isb_pkg::isb_stat_t          stat,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [isb_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic [isb_pkg::REC_AW-1:0]  slot,
    input  logic signed [isb_pkg::KEY_W-1:0] key,
    input  logic [isb_pkg::REC_AW-1:0]  block_start,
    output logic                        found,
    output logic [isb_pkg::CNT_W-1:0]   position,
    output logic [isb_pkg::PROBE_W-1:0] index_probes,
    output logic [isb_pkg::CNT_W-1:0]   block_compares
);

    localparam int CW  = isb_pkg::CNT_W;
    localparam int BW  = isb_pkg::BCNT_W;
    localparam int KW  = isb_pkg::KEY_W;
    localparam int RAW = isb_pkg::REC_AW;
    localparam int BAW = isb_pkg::BLK_AW;

    // Configuration registers
    logic [CW-1:0] rec_cnt_reg;
    logic [BW-1:0] blk_cnt_reg;

    // Tables
    logic signed [KW-1:0]  rec_mem [isb_pkg::MAX_RECORDS];
    logic signed [KW-1:0]  max_keys_reg [isb_pkg::MAX_BLOCKS];
    logic [RAW-1:0]        starts_reg   [isb_pkg::MAX_BLOCKS];
    logic signed [KW-1:0]  rd_data_reg;

    // Search working registers
    logic signed [KW-1:0]  key_reg;
    logic [CW-1:0]         n_reg;
    logic [BW-1:0]         b_reg;
    logic [CW-1:0]         quo_reg;
    logic [BW-1:0]         rem_reg;
    logic [BW-1:0]         lo_reg, hi_reg;
    logic [CW-1:0]         idx_reg, end_reg, pend_pos_reg;
    logic                  pend_vld_reg;
    logic                  found_reg;
    logic [CW-1:0]         pos_reg;
    logic [isb_pkg::PROBE_W-1:0] probes_reg;
    logic [CW-1:0]         compares_reg;

    logic [CW-1:0]         n_sat;
    logic [BW-1:0]         b_sat;
    logic [CW:0]           dvd_sum;
    logic [BW:0]           rem_sh;
    logic                  q_bit;
    logic [BW:0]           mid_sum;
    logic [BAW-1:0]        mid;
    logic                  probe_ge;
    logic                  match;

    // Clamp the counts
    always_comb
    begin
        n_sat = (rec_cnt_reg > CW'(isb_pkg::MAX_RECORDS)) ?
                CW'(isb_pkg::MAX_RECORDS) : rec_cnt_reg;
        if (blk_cnt_reg > BW'(isb_pkg::MAX_BLOCKS))
        begin
            b_sat = BW'(isb_pkg::MAX_BLOCKS);
        end
        else if (blk_cnt_reg == '0)
        begin
            b_sat = BW'(1);
        end
        else
        begin
            b_sat = blk_cnt_reg;
        end
        dvd_sum = {1'b0, n_sat} + {{(CW+1-BW){1'b0}}, b_sat} - (CW+1)'(1);
    end

    // Restoring divider step
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[CW-1]};
        q_bit  = (rem_sh >= {1'b0, b_reg});
    end

    // Index probe
    always_comb
    begin
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (BW+1)'(1);
        mid      = mid_sum[BAW:1];
        probe_ge = (max_keys_reg[mid] >= key_reg);
    end

    assign match = pend_vld_reg && (rd_data_reg == key_reg);

    always_comb
    begin
        stat.bs_done   = (lo_reg >= hi_reg);
        stat.lo_valid  = (lo_reg < b_reg);
        stat.scan_more = (idx_reg < end_reg) && (idx_reg < n_reg);
        stat.pend_vld  = pend_vld_reg;
        stat.match     = match;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_cnt_reg <= CW'(1);
            blk_cnt_reg <= BW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                isb_pkg::CFG_RECORD_COUNT: rec_cnt_reg <= cfg_wdata;
                isb_pkg::CFG_BLOCK_COUNT:  blk_cnt_reg <= cfg_wdata[BW-1:0];
            endcase
        end
    end

    // Record table: write on load beats, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (cmd.wr_rec)
        begin
            rec_mem[slot] <= key;
        end
        if (cmd.scan_run && stat.scan_more)
        begin
            rd_data_reg <= rec_mem[idx_reg[RAW-1:0]];
        end
    end

    // Index table: drop writes beyond its depth
    always_ff @(posedge clk)
    begin
        if (cmd.wr_idx && (slot < RAW'(isb_pkg::MAX_BLOCKS)))
        begin
            max_keys_reg[slot[BAW-1:0]] <= key;
            starts_reg[slot[BAW-1:0]]   <= block_start;
        end
    end

    // Search control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
        end
        else if (cmd.init || cmd.scan_setup)
        begin
            pend_vld_reg <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            pend_vld_reg <= stat.scan_more;
        end
    end

    // Search datapath
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            key_reg      <= key;
            n_reg        <= n_sat;
            b_reg        <= b_sat;
            quo_reg      <= dvd_sum[CW-1:0];
            rem_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= b_sat;
            idx_reg      <= '0;
            end_reg      <= '0;
            found_reg    <= 1'b0;
            pos_reg      <= '0;
            probes_reg   <= '0;
            compares_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? BW'(rem_sh - {1'b0, b_reg}) : rem_sh[BW-1:0];
            quo_reg <= {quo_reg[CW-2:0], q_bit};
        end
        if (cmd.bs_step)
        begin
            if (probe_ge)
            begin
                hi_reg <= {1'b0, mid};
            end
            else
            begin
                lo_reg <= {1'b0, mid} + BW'(1);
            end
            probes_reg <= probes_reg + 1'b1;
        end
        if (cmd.scan_setup)
        begin
            idx_reg <= {1'b0, starts_reg[lo_reg[BAW-1:0]]};
            end_reg <= {1'b0, starts_reg[lo_reg[BAW-1:0]]} + quo_reg;
        end
        if (cmd.scan_run)
        begin
            if (stat.scan_more)
            begin
                idx_reg      <= idx_reg + 1'b1;
                pend_pos_reg <= idx_reg + 1'b1;
            end
            if (pend_vld_reg)
            begin
                compares_reg <= compares_reg + 1'b1;
            end
            if (match)
            begin
                found_reg <= 1'b1;
                pos_reg   <= pend_pos_reg;
            end
        end
    end

    assign found          = found_reg;
    assign position       = pos_reg;
    assign index_probes   = probes_reg;
    assign block_compares = compares_reg;

endmodule

// ===== src/indexed_block_search.sv =====
// Top level of the indexed block search: controller plus datapath.
//
//  channel   handshake            payload
//  input     start & !busy        func, slot, key, block_start
//  result    done (one cycle)     found, position, index_probes, block_compares
//  config    cfg_we               cfg_index, cfg_wdata
//
// Load beats (record or index write) finish in the cycle they are taken.
// A search computes the block size (record count over block count, rounded up)
// with a restoring divider, then runs a binary search of the index (up to 5
// probes) until the interval is empty, sets up the scan bounds from the chosen
// block, and reads and compares its records until a match or the scan drains,
// then shows done. A key above every block goes straight to done after the
// index search.
// Reset clears the controller and sets both counts to one; tables are not cleared.
// The receiver cannot stall: done flags the results, which hold until the next search.
`timescale 1ns / 1ps

module indexed_block_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  func,
    input  logic [isb_pkg::REC_AW-1:0]  slot,
    input  logic signed [isb_pkg::KEY_W-1:0] key,
    input  logic [isb_pkg::REC_AW-1:0]  block_start,
    output logic                        done,
    output logic                        found,
    output logic [isb_pkg::CNT_W-1:0]   position,
    output logic [isb_pkg::PROBE_W-1:0] index_probes,
    output logic [isb_pkg::CNT_W-1:0]   block_compares,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [isb_pkg::CNT_W-1:0]   cfg_wdata
);

    isb_pkg::isb_cmd_t  cmd;
    isb_pkg::isb_stat_t stat;

    isb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    isb_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .slot           (slot),
        .key            (key),
        .block_start    (block_start),
        .found          (found),
        .position       (position),
        .index_probes   (index_probes),
        .block_compares (block_compares)
    );

endmodule
